// File: hw/rtl/salc_pkg.sv
// Shared constants, types and address helpers for the set-associative LRU
// write-back cache model. Used by the top level, salc_ctrl, salc_dpath and the testbench.
`default_nettype none

package salc_pkg;

	localparam int WAYS              = 2;
	localparam int SETS              = 1024;
	localparam int BLOCK_OFFSET_BITS = 5;
	localparam int ADDRESS_BITS      = 32;

	localparam int ADDR_W    = 32;
	localparam int ICNT_W    = 16;
	localparam int PENALTY_W = 10;
	localparam int CYC_W     = 17;
	localparam int CNT_W     = 32;
	localparam int SUM_W     = 48;

	localparam logic [PENALTY_W-1:0] MISS_PENALTY_RESET = 10'd30;
	localparam logic [CYC_W-1:0]     DIRTY_EVICT_COST   = 17'd2;

	localparam int INDEX_BITS = $clog2(SETS + 1) - 1;
	localparam int SET_AW     = (INDEX_BITS > 0) ? INDEX_BITS : 1;
	localparam int ROWS       = 2 ** INDEX_BITS;
	localparam int TAG_RAW    = ADDRESS_BITS - BLOCK_OFFSET_BITS - INDEX_BITS;
	localparam int TAG_W      = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam logic [63:0] ADDR_MASK =
		(ADDRESS_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDRESS_BITS) - 64'd1);
	localparam logic [63:0] IDX_MASK  = (64'd1 << INDEX_BITS) - 64'd1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	typedef struct packed {
		logic clear_wr;
		logic load_in;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
	} ctrl_sts_t;

	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [WAY_W-1:0] age;
		logic [TAG_W-1:0] tag;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	function automatic row_t clear_row();
		row_t r;
		for (int w = 0; w < WAYS; w++) begin
			r[w].valid = 1'b0;
			r[w].dirty = 1'b0;
			r[w].age   = WAY_W'(WAYS - 1 - w);
			r[w].tag   = '0;
		end
		return r;
	endfunction

	function automatic logic [SET_AW-1:0] addr_index(input logic [ADDR_W-1:0] a);
		logic [63:0] x;
		x = ({32'b0, a} & ADDR_MASK) >> BLOCK_OFFSET_BITS;
		return SET_AW'(x & IDX_MASK);
	endfunction

	function automatic logic [TAG_W-1:0] addr_tag(input logic [ADDR_W-1:0] a);
		logic [63:0] x;
		x = ({32'b0, a} & ADDR_MASK) >> (BLOCK_OFFSET_BITS + INDEX_BITS);
		return TAG_W'(x);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/set_assoc_lru_writeback_cache.sv
// Top level of the set-associative LRU write-back cache model: one result item
// per trace item. The set row is read from the set RAM in the accept cycle;
// then, once the result register has room, tags, ages and dirty bits are
// written back and the result register is loaded. Lookup holds while the
// result register is full and out_stall is high; an item can be accepted while
// the previous result waits. After reset a clearing pass writes all 1024 set
// rows, one row a cycle, with in_stall high throughout the pass. The miss
// penalty register is always ready and is written whenever cfg_valid is high.
// Depends on salc_pkg, salc_ctrl, salc_dpath and salc_ram.
`default_nettype none

module set_assoc_lru_writeback_cache (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [salc_pkg::PENALTY_W-1:0]       cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 opcode,
	input  wire logic [salc_pkg::ADDR_W-1:0]          address,
	input  wire logic [salc_pkg::ICNT_W-1:0]          instr_count,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      hit,
	output logic                                      dirty_evict,
	output logic      [salc_pkg::CYC_W-1:0]           cycles_added,
	output logic      [salc_pkg::CNT_W-1:0]           load_hit_total,
	output logic      [salc_pkg::CNT_W-1:0]           load_miss_total,
	output logic      [salc_pkg::CNT_W-1:0]           store_hit_total,
	output logic      [salc_pkg::CNT_W-1:0]           store_miss_total,
	output logic      [salc_pkg::CNT_W-1:0]           dirty_evict_total,
	output logic      [salc_pkg::SUM_W-1:0]           total_cycles,
	output logic      [salc_pkg::SUM_W-1:0]           instr_total,
	output logic      [salc_pkg::CNT_W-1:0]           access_total
);
	import salc_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	salc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	salc_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_valid        (cfg_valid),
		.cfg_data         (cfg_data),
		.opcode           (opcode),
		.address          (address),
		.instr_count      (instr_count),
		.hit              (hit),
		.dirty_evict      (dirty_evict),
		.cycles_added     (cycles_added),
		.load_hit_total   (load_hit_total),
		.load_miss_total  (load_miss_total),
		.store_hit_total  (store_hit_total),
		.store_miss_total (store_miss_total),
		.dirty_evict_total(dirty_evict_total),
		.total_cycles     (total_cycles),
		.instr_total      (instr_total),
		.access_total     (access_total)
	);

`ifndef NO_ASSERTIONS
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted item did not hold off the next one");

	a_commit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit did not present a result item");

	a_commit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || !out_stall))
		else $error("commit overwrote a result item still waiting");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && dirty_evict))
		else $error("hit reported together with a dirty eviction");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/salc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; holds the per-set line rows of the cache.
`default_nettype none

module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                           wr_data,
	input  wire logic                                       rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/salc_ctrl.sv
// Controller state machine: clearing pass, item accept, lookup and commit.
// Depends on salc_pkg for the state and command types.
`default_nettype none

module salc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output salc_pkg::ctrl_cmd_t       cmd,
	input  wire salc_pkg::ctrl_sts_t  sts
);
	import salc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (sts.clear_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_LOOKUP;
			ST_LOOKUP: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
			end
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.load_in = in_valid;
			end
			ST_LOOKUP: begin
				cmd.commit = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/salc_dpath.sv
// Datapath: set RAM, tag compare, LRU update, victim choice and statistics.
// Depends on salc_pkg and salc_ram; driven by commands from salc_ctrl.
`default_nettype none

module salc_dpath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire salc_pkg::ctrl_cmd_t                   cmd,
	output salc_pkg::ctrl_sts_t                        sts,
	input  wire logic                                  cfg_valid,
	input  wire logic [salc_pkg::PENALTY_W-1:0]        cfg_data,
	input  wire logic                                  opcode,
	input  wire logic [salc_pkg::ADDR_W-1:0]           address,
	input  wire logic [salc_pkg::ICNT_W-1:0]           instr_count,
	output logic                                       hit,
	output logic                                       dirty_evict,
	output logic      [salc_pkg::CYC_W-1:0]            cycles_added,
	output logic      [salc_pkg::CNT_W-1:0]            load_hit_total,
	output logic      [salc_pkg::CNT_W-1:0]            load_miss_total,
	output logic      [salc_pkg::CNT_W-1:0]            store_hit_total,
	output logic      [salc_pkg::CNT_W-1:0]            store_miss_total,
	output logic      [salc_pkg::CNT_W-1:0]            dirty_evict_total,
	output logic      [salc_pkg::SUM_W-1:0]            total_cycles,
	output logic      [salc_pkg::SUM_W-1:0]            instr_total,
	output logic      [salc_pkg::CNT_W-1:0]            access_total
);
	import salc_pkg::*;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
		return (a == {CNT_W{1'b1}}) ? a : a + 1'b1;
	endfunction

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	logic [PENALTY_W-1:0] penalty_q;
	logic [SET_AW-1:0]    clr_cnt_q;
	logic                 op_q;
	logic [SET_AW-1:0]    idx_q;
	logic [TAG_W-1:0]     tag_q;
	logic [ICNT_W-1:0]    icnt_q;
	logic [ROW_W-1:0]     rd_data;
	logic                 wr_en;
	logic [SET_AW-1:0]    wr_addr;
	logic [ROW_W-1:0]     wr_data;

	row_t                 row_rd;
	row_t                 row_wr;
	logic                 hit_any;
	logic [WAY_W-1:0]     hit_way;
	logic                 inv_any;
	logic [WAY_W-1:0]     inv_way;
	logic [WAY_W-1:0]     lru_way;
	logic [WAY_W-1:0]     vic;
	logic [WAY_W-1:0]     cur_age;
	logic                 devict;
	logic [CYC_W-1:0]     cycles;

	logic                 hit_q;
	logic                 devict_q;
	logic [CYC_W-1:0]     cycles_q;
	logic [CNT_W-1:0]     lhit_q;
	logic [CNT_W-1:0]     lmiss_q;
	logic [CNT_W-1:0]     shit_q;
	logic [CNT_W-1:0]     smiss_q;
	logic [CNT_W-1:0]     dirty_q;
	logic [SUM_W-1:0]     cyc_q;
	logic [SUM_W-1:0]     instr_q;
	logic [CNT_W-1:0]     acc_q;

	assign sts.clear_last = (clr_cnt_q == SET_AW'(ROWS - 1));

	assign wr_en   = cmd.clear_wr || cmd.commit;
	assign wr_addr = cmd.clear_wr ? clr_cnt_q : idx_q;
	assign wr_data = cmd.clear_wr ? ROW_W'(clear_row()) : ROW_W'(row_wr);

	salc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROWS)
	) u_set_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.load_in),
		.rd_addr(addr_index(address)),
		.rd_data(rd_data)
	);

	always_comb begin
		row_rd  = row_t'(rd_data);
		hit_any = 1'b0;
		hit_way = '0;
		inv_any = 1'b0;
		inv_way = '0;
		lru_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_rd[w].valid && row_rd[w].tag == tag_q) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!row_rd[w].valid) begin
				inv_any = 1'b1;
				inv_way = WAY_W'(w);
			end
			if (row_rd[w].age == WAY_W'(WAYS - 1)) begin
				lru_way = WAY_W'(w);
			end
		end
		vic     = hit_any ? hit_way : (inv_any ? inv_way : lru_way);
		devict  = !hit_any && !inv_any && row_rd[lru_way].dirty;
		cur_age = row_rd[vic].age;
		row_wr  = row_rd;
		for (int w = 0; w < WAYS; w++) begin
			if (cur_age > row_rd[w].age) begin
				row_wr[w].age = row_rd[w].age + 1'b1;
			end
		end
		row_wr[vic].age   = '0;
		row_wr[vic].valid = 1'b1;
		row_wr[vic].tag   = tag_q;
		row_wr[vic].dirty = hit_any ? (row_rd[vic].dirty | op_q) : op_q;
		cycles = CYC_W'(icnt_q) + (hit_any ? '0 : CYC_W'(penalty_q))
			+ (devict ? DIRTY_EVICT_COST : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_q <= MISS_PENALTY_RESET;
			clr_cnt_q <= '0;
			lhit_q    <= '0;
			lmiss_q   <= '0;
			shit_q    <= '0;
			smiss_q   <= '0;
			dirty_q   <= '0;
			cyc_q     <= '0;
			instr_q   <= '0;
			acc_q     <= '0;
		end else begin
			if (cfg_valid) begin
				penalty_q <= cfg_data;
			end
			if (cmd.clear_wr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.commit) begin
				if (hit_any && !op_q)  lhit_q  <= sat_inc(lhit_q);
				if (!hit_any && !op_q) lmiss_q <= sat_inc(lmiss_q);
				if (hit_any && op_q)   shit_q  <= sat_inc(shit_q);
				if (!hit_any && op_q)  smiss_q <= sat_inc(smiss_q);
				if (devict)            dirty_q <= sat_inc(dirty_q);
				cyc_q   <= sat_add(cyc_q, SUM_W'(cycles));
				instr_q <= sat_add(instr_q, SUM_W'(icnt_q));
				acc_q   <= sat_inc(acc_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= opcode;
			idx_q  <= addr_index(address);
			tag_q  <= addr_tag(address);
			icnt_q <= instr_count;
		end
		if (cmd.commit) begin
			hit_q    <= hit_any;
			devict_q <= devict;
			cycles_q <= cycles;
		end
	end

	assign hit               = hit_q;
	assign dirty_evict       = devict_q;
	assign cycles_added      = cycles_q;
	assign load_hit_total    = lhit_q;
	assign load_miss_total   = lmiss_q;
	assign store_hit_total   = shit_q;
	assign store_miss_total  = smiss_q;
	assign dirty_evict_total = dirty_q;
	assign total_cycles      = cyc_q;
	assign instr_total       = instr_q;
	assign access_total      = acc_q;

endmodule

`default_nettype wire

// File: test/set_assoc_lru_writeback_cache_tb.sv
// Self-checking testbench for the 2-way LRU write-back cache: drives load/store trace items,
// predicts hit, eviction, added cycles and running totals, and compares every result item.
// Depends on salc_pkg and set_assoc_lru_writeback_cache.
`default_nettype none

module set_assoc_lru_writeback_cache_tb;
	import salc_pkg::*;

	typedef enum logic {
		ACC_LOAD  = 1'b0,
		ACC_STORE = 1'b1
	} access_kind_t;

	typedef struct {
		access_kind_t      op;
		logic [ADDR_W-1:0] addr;
		logic [ICNT_W-1:0] icnt;
	} trace_item_t;

	typedef struct {
		logic             hit;
		logic             dirty_evict;
		logic [CYC_W-1:0] cycles;
		logic [CNT_W-1:0] ld_hit_cnt;
		logic [CNT_W-1:0] ld_miss_cnt;
		logic [CNT_W-1:0] st_hit_cnt;
		logic [CNT_W-1:0] st_miss_cnt;
		logic [CNT_W-1:0] dirty_evicts;
		logic [SUM_W-1:0] cycle_sum;
		logic [SUM_W-1:0] instr_sum;
		logic [CNT_W-1:0] accesses;
	} cache_outcome_t;

	localparam longint unsigned CNT_MAX  = 64'hFFFF_FFFF;
	localparam longint unsigned SUM_MAX  = 64'hFFFF_FFFF_FFFF;
	localparam int              HOLD_LEN = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [PENALTY_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = 1'b0;
	logic [ADDR_W-1:0] address = '0;
	logic [ICNT_W-1:0] instr_count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic dirty_evict;
	logic [CYC_W-1:0] cycles_added;
	logic [CNT_W-1:0] load_hit_total;
	logic [CNT_W-1:0] load_miss_total;
	logic [CNT_W-1:0] store_hit_total;
	logic [CNT_W-1:0] store_miss_total;
	logic [CNT_W-1:0] dirty_evict_total;
	logic [SUM_W-1:0] total_cycles;
	logic [SUM_W-1:0] instr_total;
	logic [CNT_W-1:0] access_total;

	set_assoc_lru_writeback_cache uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.address(address),
		.instr_count(instr_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.dirty_evict(dirty_evict),
		.cycles_added(cycles_added),
		.load_hit_total(load_hit_total),
		.load_miss_total(load_miss_total),
		.store_hit_total(store_hit_total),
		.store_miss_total(store_miss_total),
		.dirty_evict_total(dirty_evict_total),
		.total_cycles(total_cycles),
		.instr_total(instr_total),
		.access_total(access_total)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// cache image and statistics of the predictor
	logic             m_valid [ROWS][WAYS];
	logic [TAG_W-1:0] m_tag   [ROWS][WAYS];
	int               m_age   [ROWS][WAYS];
	logic             m_dirty [ROWS][WAYS];
	longint unsigned  n_load_hit, n_load_miss, n_store_hit, n_store_miss, n_dirty;
	longint unsigned  n_cycles, n_instr, n_access;
	logic [PENALTY_W-1:0] penalty_q = MISS_PENALTY_RESET;

	trace_item_t    access_queue[$];
	cache_outcome_t outcome_queue[$];
	trace_item_t    next_access;
	cache_outcome_t oldest_outcome;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit send_hold = 1'b0;
	bit hold_request = 1'b0;
	logic recv_hold = 1'b0;
	int hold_left = 0;
	int mismatches = 0;

	function automatic longint unsigned sat_sum(input longint unsigned a,
			input longint unsigned b, input longint unsigned max);
		if (a >= max || b >= max - a)
			return max;
		return a + b;
	endfunction

	function automatic cache_outcome_t simulate_access(input access_kind_t op,
			input logic [ADDR_W-1:0] addr, input logic [ICNT_W-1:0] icnt);
		cache_outcome_t   r;
		int               row;
		int               way;
		int               cur;
		logic [TAG_W-1:0] tg;
		bit               hit_f;
		bit               found;
		bit               dev;
		longint unsigned  cyc;
		row = int'((addr >> BLOCK_OFFSET_BITS) & (ROWS - 1));
		tg = TAG_W'(addr >> (BLOCK_OFFSET_BITS + INDEX_BITS));
		hit_f = 1'b0;
		found = 1'b0;
		dev = 1'b0;
		way = 0;
		for (int w = 0; w < WAYS; w++)
			if (!hit_f && m_valid[row][w] && m_tag[row][w] == tg) begin
				hit_f = 1'b1;
				way = w;
			end
		if (!hit_f) begin
			for (int w = WAYS - 1; w >= 0; w--)
				if (!m_valid[row][w]) begin
					way = w;
					found = 1'b1;
				end
			if (!found) begin
				way = 0;
				for (int w = WAYS - 1; w >= 0; w--)
					if (m_age[row][w] == WAYS - 1)
						way = w;
				dev = m_dirty[row][way];
			end
			m_valid[row][way] = 1'b1;
			m_tag[row][way] = tg;
		end
		cur = m_age[row][way];
		for (int w = 0; w < WAYS; w++)
			if (cur > m_age[row][w])
				m_age[row][w]++;
		m_age[row][way] = 0;
		if (hit_f) begin
			if (op == ACC_STORE)
				m_dirty[row][way] = 1'b1;
		end else begin
			m_dirty[row][way] = (op == ACC_STORE);
		end
		cyc = longint'(icnt) + (hit_f ? 0 : longint'(penalty_q)) + (dev ? 2 : 0);
		if (hit_f && op == ACC_STORE)
			n_store_hit = sat_sum(n_store_hit, 1, CNT_MAX);
		else if (hit_f)
			n_load_hit = sat_sum(n_load_hit, 1, CNT_MAX);
		else if (op == ACC_STORE)
			n_store_miss = sat_sum(n_store_miss, 1, CNT_MAX);
		else
			n_load_miss = sat_sum(n_load_miss, 1, CNT_MAX);
		if (dev)
			n_dirty = sat_sum(n_dirty, 1, CNT_MAX);
		n_cycles = sat_sum(n_cycles, cyc, SUM_MAX);
		n_instr = sat_sum(n_instr, longint'(icnt), SUM_MAX);
		n_access = sat_sum(n_access, 1, CNT_MAX);
		r.hit = hit_f;
		r.dirty_evict = dev;
		r.cycles = CYC_W'(cyc);
		r.ld_hit_cnt = CNT_W'(n_load_hit);
		r.ld_miss_cnt = CNT_W'(n_load_miss);
		r.st_hit_cnt = CNT_W'(n_store_hit);
		r.st_miss_cnt = CNT_W'(n_store_miss);
		r.dirty_evicts = CNT_W'(n_dirty);
		r.cycle_sum = SUM_W'(n_cycles);
		r.instr_sum = SUM_W'(n_instr);
		r.accesses = CNT_W'(n_access);
		return r;
	endfunction

	function automatic trace_item_t trace_rec(input access_kind_t op,
			input logic [ADDR_W-1:0] addr, input logic [ICNT_W-1:0] icnt);
		trace_item_t t;
		t.op = op;
		t.addr = addr;
		t.icnt = icnt;
		return t;
	endfunction

	task automatic check_field(input string fname, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h", fname, want, got);
		end
	endtask

	// driver: offer trace items, hold the payload while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				outcome_queue.push_back(simulate_access(access_kind_t'(opcode), address,
					instr_count));
			if (!in_valid || !in_stall) begin
				if (access_queue.size() != 0 && !send_hold &&
						$urandom_range(99) >= send_idle_pct) begin
					next_access = access_queue.pop_front();
					in_valid <= 1'b1;
					opcode <= next_access.op;
					address <= next_access.addr;
					instr_count <= next_access.icnt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (!arst_n) begin
			recv_hold <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			if (hold_left == 1)
				recv_hold <= 1'b0;
		end else if (hold_request) begin
			recv_hold <= 1'b1;
			hold_left <= HOLD_LEN;
		end
	end

	// monitor: compare each accepted result item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (outcome_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result item with no prediction pending");
				end else begin
					oldest_outcome = outcome_queue.pop_front();
					check_field("hit", SUM_W'(oldest_outcome.hit), SUM_W'(hit));
					check_field("dirty_evict", SUM_W'(oldest_outcome.dirty_evict),
						SUM_W'(dirty_evict));
					check_field("cycles_added", SUM_W'(oldest_outcome.cycles),
						SUM_W'(cycles_added));
					check_field("load_hit_total", SUM_W'(oldest_outcome.ld_hit_cnt),
						SUM_W'(load_hit_total));
					check_field("load_miss_total", SUM_W'(oldest_outcome.ld_miss_cnt),
						SUM_W'(load_miss_total));
					check_field("store_hit_total", SUM_W'(oldest_outcome.st_hit_cnt),
						SUM_W'(store_hit_total));
					check_field("store_miss_total", SUM_W'(oldest_outcome.st_miss_cnt),
						SUM_W'(store_miss_total));
					check_field("dirty_evict_total", SUM_W'(oldest_outcome.dirty_evicts),
						SUM_W'(dirty_evict_total));
					check_field("total_cycles", oldest_outcome.cycle_sum, total_cycles);
					check_field("instr_total", oldest_outcome.instr_sum, instr_total);
					check_field("access_total", SUM_W'(oldest_outcome.accesses),
						SUM_W'(access_total));
				end
			end
			out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic drain_all();
		while (access_queue.size() != 0 || in_valid || outcome_queue.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic run_phase(input logic [PENALTY_W-1:0] pen, input int n_items,
			input int s_idle, input int r_stall, input bit long_hold, input bit mid_pause);
		trace_item_t      t;
		int               row;
		logic [TAG_W-1:0] tg;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= pen;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		penalty_q = pen;
		@(negedge clk);
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		hold_request = long_hold;
		for (int i = 0; i < n_items; i++) begin
			t.op = access_kind_t'($urandom_range(1));
			if ($urandom_range(9) < 2) begin
				t.addr = $urandom;
			end else begin
				row = ($urandom_range(3) == 0) ? $urandom_range(ROWS - 1) : $urandom_range(3);
				tg = ($urandom_range(7) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(3));
				t.addr = (ADDR_W'(tg) << (BLOCK_OFFSET_BITS + INDEX_BITS)) |
					(ADDR_W'(row) << BLOCK_OFFSET_BITS) |
					ADDR_W'($urandom_range((1 << BLOCK_OFFSET_BITS) - 1));
			end
			case ($urandom_range(7))
				0: t.icnt = '0;
				1: t.icnt = '1;
				2: t.icnt = ICNT_W'($urandom_range(15));
				default: t.icnt = ICNT_W'($urandom);
			endcase
			access_queue.push_back(t);
		end
		@(negedge clk);
		hold_request = 1'b0;
		if (mid_pause) begin
			while (access_queue.size() > n_items / 2)
				@(negedge clk);
			send_hold = 1'b1;
			while (in_valid || outcome_queue.size() != 0)
				@(negedge clk);
			send_hold = 1'b0;
		end
		drain_all();
	endtask

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		for (int s = 0; s < ROWS; s++)
			for (int w = 0; w < WAYS; w++) begin
				m_valid[s][w] = 1'b0;
				m_tag[s][w] = '0;
				m_age[s][w] = WAYS - 1 - w;
				m_dirty[s][w] = 1'b0;
			end
		n_load_hit = 0;
		n_load_miss = 0;
		n_store_hit = 0;
		n_store_miss = 0;
		n_dirty = 0;
		n_cycles = 0;
		n_instr = 0;
		n_access = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		access_queue.push_back(trace_rec(ACC_LOAD, 32'h0000_0000, 16'd0));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'h0000_001F, 16'hFFFF));
		access_queue.push_back(trace_rec(ACC_STORE, 32'h0000_0000, 16'd1));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'h0000_8000, 16'd2));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'h0001_0000, 16'd3));
		access_queue.push_back(trace_rec(ACC_STORE, 32'h0000_8004, 16'd4));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'h0000_0008, 16'd5));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'h0001_0010, 16'd6));
		access_queue.push_back(trace_rec(ACC_STORE, 32'h0000_0020, 16'd7));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'h0000_003F, 16'd8));
		access_queue.push_back(trace_rec(ACC_STORE, 32'hFFFF_FFFF, 16'hFFFF));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'hFFFF_FFE0, 16'd0));
		access_queue.push_back(trace_rec(ACC_STORE, 32'h0000_7FE0, 16'd9));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'h7FFF_FFFF, 16'd10));
		access_queue.push_back(trace_rec(ACC_STORE, 32'hAAAA_AAAA, 16'hAAAA));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'h5555_5555, 16'h5555));
		access_queue.push_back(trace_rec(ACC_STORE, 32'hAAAA_AAAA, 16'hFFFF));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'h0000_7FFF, 16'd0));
		access_queue.push_back(trace_rec(ACC_LOAD, 32'hFFFF_8000, 16'd1));
		access_queue.push_back(trace_rec(ACC_STORE, 32'h8000_0000, 16'd12345));
		drain_all();
		run_phase('0, 210, 0, 0, 1'b0, 1'b0);
		run_phase('1, 210, 63, 0, 1'b0, 1'b0);
		run_phase(PENALTY_W'($urandom_range(1023)), 210, 0, 63, 1'b1, 1'b0);
		run_phase(MISS_PENALTY_RESET, 210, 27, 27, 1'b0, 1'b1);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && outcome_queue.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
